// ===== hdl/ffc_pkg.sv =====
// Shared types and constants for the four-function calculator.
// No dependencies; imported by four_function_calculator.
package ffc_pkg;

  // Key kinds on the input channel
  typedef enum logic [1:0] {
    CMD_DIGIT  = 2'd0,
    CMD_OPER   = 2'd1,
    CMD_EQUALS = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // Pending operator codes
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIG1,
    S_DIG2,
    S_ADDSUB,
    S_MUL,
    S_DIV_N,
    S_DIV_D,
    S_DIV_LOOP,
    S_DIV_SIGN,
    S_POST,
    S_DONE
  } state_t;

  localparam logic [31:0] DIGIT_LIMIT = 32'd100000000;
  localparam logic [3:0]  MAX_DIGIT   = 4'd9;
  localparam logic [3:0]  MAX_OPER    = 4'd3;
  localparam int          OUT_WIDTH   = 64;

endpackage

// ===== hdl/four_function_calculator.sv =====
// Keypad calculator controller: one shared adder under a small sequencer.
// Depends on ffc_pkg (key kinds, operator codes, states).
//
// Usage:
//   Input channel (in_valid / in_stall, in_cmd, in_key_value) carries one key
//   per transaction: digit, operator, equals or clear. in_stall is high while
//   a key is being worked on; one key is taken at a time.
//   Output channel (out_valid / out_stall, out_display_value) returns one
//   transaction per key: the accumulator, sign-extended to 64 bits.
// States each key passes through, W = VALUE_WIDTH; every path ends in S_DONE:
//   clear, ignored keys, digit once the entry limit is reached: S_DONE only
//   equals/operator with nothing pending or a zero divisor: S_POST
//   digit: S_DIG1, S_DIG2; add or subtract pending: S_ADDSUB, S_POST
//   multiply pending: S_MUL (shift-add, one multiplier bit per cycle), S_POST
//   divide pending: S_DIV_N, S_DIV_D, S_DIV_LOOP (restoring, one quotient bit
//     per cycle), S_DIV_SIGN, S_POST. The output register frees the sequencer:
// a new key is taken while a result still waits, but the next result holds in
// S_DONE until the receiver drops out_stall. Synchronous active-low reset
// clears state_r, acc_r, pend_r, op_r, ae_r, out_valid_r; no other register.
module four_function_calculator
  import ffc_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_cmd,
  input  logic [3:0]                  in_key_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_WIDTH-1:0] out_display_value
);

  localparam int VW = VALUE_WIDTH;
  localparam int CW = $clog2(VALUE_WIDTH);
  localparam logic [VW-1:0] LIMIT = VW'(DIGIT_LIMIT);
  localparam logic [CW-1:0] CNT_LAST = CW'(VALUE_WIDTH - 1);

  state_t                state_r, state_nxt;
  logic [VW-1:0]         acc_r, acc_nxt;
  logic [VW-1:0]         pend_r, pend_nxt;
  op_t                   op_r, op_nxt;
  logic                  ae_r, ae_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [3:0]            kv_r, kv_nxt;
  logic [VW-1:0]         wa_r, wa_nxt;
  logic [VW-1:0]         wb_r, wb_nxt;
  logic [VW-1:0]         rem_r, rem_nxt;
  logic                  neg_r, neg_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_WIDTH-1:0]  out_data_r, out_data_nxt;

  // shared adder / subtractor
  logic [VW-1:0]         ua, ub;
  logic                  usub;
  logic [VW:0]           usum;

  logic                  in_accept;
  cmd_t                  in_cmd_e;
  logic [VW-1:0]         acc0;
  logic [VW-1:0]         shifted;
  logic                  qbit;

  assign usum = {1'b0, ua} + {1'b0, (usub ? ~ub : ub)} + (VW+1)'(usub);

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_cmd_e  = cmd_t'(in_cmd);

  assign out_valid         = out_valid_r;
  assign out_display_value = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      pend_r      <= '0;
      op_r        <= OP_NONE;
      ae_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      pend_r      <= pend_nxt;
      op_r        <= op_nxt;
      ae_r        <= ae_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    kv_r       <= kv_nxt;
    wa_r       <= wa_nxt;
    wb_r       <= wb_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    pend_nxt      = pend_r;
    op_nxt        = op_r;
    ae_nxt        = ae_r;
    cmd_nxt       = cmd_r;
    kv_nxt        = kv_r;
    wa_nxt        = wa_r;
    wb_nxt        = wb_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    ua            = acc_r;
    ub            = acc_r;
    usub          = 1'b0;
    acc0          = ae_r ? '0 : acc_r;
    shifted       = {rem_r[VW-2:0], wb_r[VW-1]};
    qbit          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd_nxt   = in_cmd_e;
          kv_nxt    = in_key_value;
          state_nxt = S_DONE;
          case (in_cmd_e)
            CMD_DIGIT: begin
              if (in_key_value <= MAX_DIGIT) begin
                acc_nxt = acc0;
                ae_nxt  = 1'b0;
                if (acc0[VW-1] || (acc0 < LIMIT)) begin
                  state_nxt = S_DIG1;
                end
              end
            end
            CMD_OPER, CMD_EQUALS: begin
              if ((in_cmd_e == CMD_EQUALS) || (in_key_value <= MAX_OPER)) begin
                state_nxt = S_POST;
                case (op_r)
                  OP_ADD, OP_SUB: begin
                    state_nxt = S_ADDSUB;
                  end
                  OP_MUL: begin
                    rem_nxt   = '0;
                    wa_nxt    = pend_r;
                    wb_nxt    = acc_r;
                    cnt_nxt   = CNT_LAST;
                    state_nxt = S_MUL;
                  end
                  OP_DIV: begin
                    if (acc_r == '0) begin
                      // divide by zero gives zero
                      op_nxt   = OP_NONE;
                      pend_nxt = '0;
                    end else begin
                      state_nxt = S_DIV_N;
                    end
                  end
                  default: begin
                    op_nxt   = OP_NONE;
                    pend_nxt = '0;
                  end
                endcase
              end
            end
            CMD_CLEAR: begin
              acc_nxt  = '0;
              pend_nxt = '0;
              op_nxt   = OP_NONE;
              ae_nxt   = 1'b0;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_DIG1: begin
        // acc*8 + acc*2
        ua        = {acc_r[VW-4:0], 3'b000};
        ub        = {acc_r[VW-2:0], 1'b0};
        acc_nxt   = usum[VW-1:0];
        state_nxt = S_DIG2;
      end

      S_DIG2: begin
        ua        = acc_r;
        ub        = {{(VW-4){1'b0}}, kv_r};
        acc_nxt   = usum[VW-1:0];
        state_nxt = S_DONE;
      end

      S_ADDSUB: begin
        ua        = pend_r;
        ub        = acc_r;
        usub      = (op_r == OP_SUB);
        acc_nxt   = usum[VW-1:0];
        op_nxt    = OP_NONE;
        pend_nxt  = '0;
        state_nxt = S_POST;
      end

      S_MUL: begin
        ua      = rem_r;
        ub      = wa_r;
        rem_nxt = wb_r[0] ? usum[VW-1:0] : rem_r;
        wa_nxt  = {wa_r[VW-2:0], 1'b0};
        wb_nxt  = {1'b0, wb_r[VW-1:1]};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          acc_nxt   = rem_nxt;
          op_nxt    = OP_NONE;
          pend_nxt  = '0;
          state_nxt = S_POST;
        end
      end

      S_DIV_N: begin
        ua        = '0;
        ub        = pend_r;
        usub      = 1'b1;
        wb_nxt    = pend_r[VW-1] ? usum[VW-1:0] : pend_r;
        neg_nxt   = pend_r[VW-1] ^ acc_r[VW-1];
        state_nxt = S_DIV_D;
      end

      S_DIV_D: begin
        ua        = '0;
        ub        = acc_r;
        usub      = 1'b1;
        wa_nxt    = acc_r[VW-1] ? usum[VW-1:0] : acc_r;
        rem_nxt   = '0;
        cnt_nxt   = CNT_LAST;
        state_nxt = S_DIV_LOOP;
      end

      S_DIV_LOOP: begin
        // trial subtract; carry out means no borrow
        ua      = shifted;
        ub      = wa_r;
        usub    = 1'b1;
        qbit    = usum[VW];
        rem_nxt = qbit ? usum[VW-1:0] : shifted;
        wb_nxt  = {wb_r[VW-2:0], qbit};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = S_DIV_SIGN;
        end
      end

      S_DIV_SIGN: begin
        ua        = '0;
        ub        = wb_r;
        usub      = 1'b1;
        acc_nxt   = neg_r ? usum[VW-1:0] : wb_r;
        op_nxt    = OP_NONE;
        pend_nxt  = '0;
        state_nxt = S_POST;
      end

      S_POST: begin
        if (cmd_r == CMD_OPER) begin
          pend_nxt = acc_r;
          acc_nxt  = '0;
          op_nxt   = op_t'(3'({1'b0, kv_r[1:0]}) + 3'd1);
          ae_nxt   = 1'b0;
        end else begin
          ae_nxt = 1'b1;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_WIDTH'($signed(acc_r));
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != S_IDLE))
    else $error("sequencer did not leave idle after a transaction");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_LOOP) |-> (rem_r < wa_r))
    else $error("divider remainder not below divisor");

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_cmd_e == CMD_CLEAR)) |=>
      ((state_r == S_DONE) && (acc_r == '0) && (pend_r == '0) && (op_r == OP_NONE)))
    else $error("clear did not zero the state");

  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && (!out_valid_r || !out_stall)) |=>
      (out_valid_r && (state_r == S_IDLE)))
    else $error("result not loaded into the output register");

endmodule
